>>> design/i2cmts_pkg.sv
`timescale 1ns / 1ps

package i2cmts_pkg;

   // default buffer depth
   localparam int BUF_DEPTH_DEFAULT = 256;

   // start item kinds
   localparam logic [1:0] KIND_WRITE      = 2'd0;
   localparam logic [1:0] KIND_READ       = 2'd1;
   localparam logic [1:0] KIND_WRITE_READ = 2'd2;
   localparam logic [1:0] KIND_UNDEF      = 2'd3;

   // item modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_EVENT = 1'b1;

   // data register load codes
   localparam logic [1:0] LOAD_NONE = 2'd0;
   localparam logic [1:0] LOAD_ADDR = 2'd1;
   localparam logic [1:0] LOAD_BUF  = 2'd2;

   // bus controller status codes
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RSTART      = 8'h10;
   localparam logic [7:0] ST_SLAW_ACK    = 8'h18;
   localparam logic [7:0] ST_SLAW_NACK   = 8'h20;
   localparam logic [7:0] ST_TXDATA_ACK  = 8'h28;
   localparam logic [7:0] ST_TXDATA_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_SLAR_ACK    = 8'h40;
   localparam logic [7:0] ST_SLAR_NACK   = 8'h48;
   localparam logic [7:0] ST_RXDATA_ACK  = 8'h50;
   localparam logic [7:0] ST_RXDATA_NACK = 8'h58;

   // control register masks
   localparam logic [6:0] CON_NONE      = 7'h00;
   localparam logic [6:0] CON_ACK       = 7'h04;
   localparam logic [6:0] CON_SI        = 7'h08;
   localparam logic [6:0] CON_ACK_SI    = 7'h0C;
   localparam logic [6:0] CON_STO_ACK   = 7'h14;
   localparam logic [6:0] CON_STA       = 7'h20;
   localparam logic [6:0] CON_STA_ACK   = 7'h24;
   localparam logic [6:0] CON_STA_SI    = 7'h28;

   typedef struct packed {
      logic       mode;
      logic [1:0] kind;
      logic [7:0] slave_addr_byte;
      logic [8:0] byte_count;
      logic [8:0] second_count;
      logic [7:0] status_code;
      logic [7:0] rx_data;
   } req_type;

   typedef struct packed {
      logic [6:0] con_set;
      logic [6:0] con_clr;
      logic [1:0] load_data;
      logic [7:0] addr_out;
      logic [7:0] buf_index;
      logic       store_rx;
      logic [7:0] store_byte;
      logic       done_res;
      logic       failed;
   } rsp_type;

   typedef struct packed {
      logic [8:0] remaining;
      logic [7:0] index_now;
      logic [7:0] addr_now;
      logic [8:0] chain_count;
      logic [7:0] chain_addr;
      logic       chain_pending;
   } state_type;

endpackage

>>> design/i2cmts_step.sv
`timescale 1ns / 1ps

module i2cmts_step #(
   parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEFAULT
) (
   input  i2cmts_pkg::state_type st,
   input  i2cmts_pkg::req_type   item,
   output i2cmts_pkg::state_type st_next,
   output i2cmts_pkg::rsp_type   rsp
);
   import i2cmts_pkg::*;

   logic [8:0] idx_inc;
   logic [7:0] idx_adv;
   logic [8:0] rem_dec;

   // buffer index advance, wraps at the buffer depth
   always_comb begin
      idx_inc = {1'b0, st.index_now} + 9'd1;
      if (int'(idx_inc) >= BUF_DEPTH) begin
         idx_adv = 8'd0;
      end else begin
         idx_adv = idx_inc[7:0];
      end
      rem_dec = st.remaining - 9'd1;
   end

   // decision for one transaction
   always_comb begin
      st_next = st;
      rsp     = '0;
      if (item.mode == MODE_START) begin
         if (item.kind != KIND_UNDEF) begin
            st_next.addr_now  = (item.kind == KIND_READ) ?
                                (item.slave_addr_byte | 8'h01) : item.slave_addr_byte;
            st_next.remaining = item.byte_count;
            st_next.index_now = 8'd0;
            if (item.kind == KIND_WRITE_READ) begin
               st_next.chain_count   = item.second_count;
               st_next.chain_addr    = item.slave_addr_byte | 8'h01;
               st_next.chain_pending = 1'b1;
            end
            rsp.con_set = CON_STA;
         end
      end else begin
         case (item.status_code)
            ST_START, ST_RSTART: begin
               rsp.load_data = LOAD_ADDR;
               rsp.addr_out  = st.addr_now;
               rsp.con_set   = CON_ACK;
               rsp.con_clr   = CON_STA_SI;
            end
            ST_SLAW_ACK: begin
               rsp.load_data     = LOAD_BUF;
               rsp.buf_index     = st.index_now;
               st_next.index_now = idx_adv;
               rsp.con_set       = CON_ACK;
               rsp.con_clr       = CON_SI;
            end
            ST_SLAW_NACK: begin
               rsp.con_set  = CON_STO_ACK;
               rsp.con_clr  = CON_STA_SI;
               rsp.done_res = 1'b1;
               rsp.failed   = 1'b1;
            end
            ST_TXDATA_ACK: begin
               st_next.remaining = rem_dec;
               if (rem_dec == 9'd0) begin
                  if (!st.chain_pending) begin
                     rsp.con_set  = CON_STO_ACK;
                     rsp.con_clr  = CON_SI;
                     rsp.done_res = 1'b1;
                  end else begin
                     // chained restart into the read phase
                     st_next.addr_now      = st.chain_addr;
                     st_next.index_now     = 8'd0;
                     st_next.remaining     = st.chain_count;
                     st_next.chain_pending = 1'b0;
                     rsp.con_set           = CON_STA;
                     rsp.con_clr           = CON_SI;
                  end
               end else begin
                  rsp.load_data     = LOAD_BUF;
                  rsp.buf_index     = st.index_now;
                  st_next.index_now = idx_adv;
                  rsp.con_set       = CON_ACK;
                  rsp.con_clr       = CON_SI;
               end
            end
            ST_TXDATA_NACK: begin
               rsp.con_set  = CON_STO_ACK;
               rsp.con_clr  = CON_SI;
               rsp.done_res = 1'b1;
            end
            ST_ARB_LOST: begin
               rsp.con_set = CON_STA_ACK;
               rsp.con_clr = CON_SI;
            end
            ST_SLAR_ACK: begin
               if (st.remaining != 9'd1) begin
                  rsp.con_set = CON_ACK;
                  rsp.con_clr = CON_SI;
               end else begin
                  rsp.con_clr = CON_ACK_SI;
               end
            end
            ST_RXDATA_ACK: begin
               rsp.store_rx      = 1'b1;
               rsp.store_byte    = item.rx_data;
               rsp.buf_index     = st.index_now;
               st_next.index_now = idx_adv;
               st_next.remaining = rem_dec;
               if (rem_dec == 9'd1) begin
                  rsp.con_clr = CON_ACK_SI;
               end else begin
                  rsp.con_set = CON_ACK;
                  rsp.con_clr = CON_SI;
               end
            end
            ST_RXDATA_NACK: begin
               rsp.store_rx   = 1'b1;
               rsp.store_byte = item.rx_data;
               rsp.buf_index  = st.index_now;
               if (!st.chain_pending) begin
                  rsp.con_set  = CON_STO_ACK;
                  rsp.con_clr  = CON_SI;
                  rsp.done_res = 1'b1;
               end else begin
                  st_next.addr_now      = st.chain_addr;
                  st_next.index_now     = 8'd0;
                  st_next.remaining     = st.chain_count;
                  st_next.chain_pending = 1'b0;
                  rsp.con_set           = CON_STA;
                  rsp.con_clr           = CON_SI;
               end
            end
            default: begin
               // unlisted code, bus error
               rsp.con_set  = CON_STO_ACK;
               rsp.con_clr  = CON_SI;
               rsp.done_res = 1'b1;
               rsp.failed   = 1'b1;
            end
         endcase
      end
   end

endmodule

>>> design/i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 1ps
// channel   ports                          direction
// request   req_valid req_ready req_data   in   start items and status events
// response  rsp_valid rsp_ready rsp_data   out  control masks, loads, strobes
//
// one response per request; a transaction passes from req to rsp through the input register,
// then the result register, and one may enter every cycle while the response is not stalled
// transfer state updates as the input register hands its item to the result register
// synchronous active-high reset clears both valid flags and the transfer state
// a stalled response holds its register; the input register still fills behind it

module i2c_master_transfer_sequencer_core #(
   parameter int BUF_DEPTH = i2cmts_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  i2cmts_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output i2cmts_pkg::rsp_type rsp_data
);
   import i2cmts_pkg::*;

   logic      in_valid_ff;
   req_type   in_item_ff;
   logic      out_valid_ff;
   rsp_type   out_item_ff;
   state_type state_ff;
   state_type state_in;
   rsp_type   result_in;
   logic      advance;

   // input register moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   i2cmts_step #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_step (
      .st      (state_ff),
      .item    (in_item_ff),
      .st_next (state_in),
      .rsp     (result_in)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_item_ff <= req_data;
      end
   end

   // transfer state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_item_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

endmodule

>>> design/i2cmts_checker.sv
`timescale 1ns / 1ps

module i2cmts_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input i2cmts_pkg::rsp_type rsp_data
);
   import i2cmts_pkg::*;

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // failure only together with done
   a_fail_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.failed |-> rsp_data.done_res)
      else $error("failed without done");

   // a store strobe never comes with a data register load
   a_store_noload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.store_rx |-> rsp_data.load_data == LOAD_NONE)
      else $error("store and load together");

   // set and clear masks never overlap
   a_mask_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.con_set & rsp_data.con_clr) == CON_NONE)
      else $error("set and clear masks overlap");

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_checker u_i2cmts_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
